@@ rtl/vmd_pkg.sv @@
package vmd_pkg;

    // delay store geometry, depth a power of two
    localparam int DELAY_DEPTH = 4096;
    localparam int AW          = $clog2(DELAY_DEPTH);
    localparam int POS_W       = AW + 24;

    // quarter-wave sine table geometry, depth a power of two
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SAW              = $clog2(SINE_TABLE_DEPTH);

    localparam int SAMPLE_W = 24;
    localparam int ACC_W    = 30;
    localparam int CFG_W    = 24;

    // register indexes
    localparam logic [1:0] CFG_DELAY_WIDTH = 2'd0;
    localparam logic [1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [1:0] CFG_WAVEFORM    = 2'd2;
    localparam logic [1:0] CFG_INTERP_MODE = 2'd3;

    // lfo shapes
    localparam logic [1:0] WAVE_SINE = 2'd0;
    localparam logic [1:0] WAVE_TRI  = 2'd1;
    localparam logic [1:0] WAVE_SAW  = 2'd2;
    localparam logic [1:0] WAVE_INV  = 2'd3;

    // interpolation modes
    localparam logic [1:0] INTERP_NEAREST = 2'd0;
    localparam logic [1:0] INTERP_LINEAR  = 2'd1;
    localparam logic [1:0] INTERP_CUBIC   = 2'd2;

    // register reset values
    localparam logic [19:0] RST_DELAY_WIDTH = 20'd122880;
    localparam logic [23:0] RST_PHASE_STEP  = 24'd178957;
    localparam logic [1:0]  RST_WAVEFORM    = WAVE_SINE;
    localparam logic [1:0]  RST_INTERP_MODE = INTERP_LINEAR;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [15:0] t_sine_tab [0:SINE_TABLE_DEPTH];

    // fixed point taylor series, evaluated at elaboration only
    function automatic t_sine_tab build_sine();
        t_sine_tab       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          e;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int n = 0; n < 7; n++) begin
                term = (term * x2) >> 30;
                // factorial step of each series term
                case (n)
                    0:       term = term / 64'd6;
                    1:       term = term / 64'd20;
                    2:       term = term / 64'd42;
                    3:       term = term / 64'd72;
                    4:       term = term / 64'd110;
                    5:       term = term / 64'd156;
                    default: term = term / 64'd210;
                endcase
                if (n % 2 == 1) sum = sum + longint'(term);
                else            sum = sum - longint'(term);
            end
            if (sum < 0) sum = 0;
            e = (sum * 32768 + (64'sd1 <<< 29)) >>> 30;
            if (e > 32768) e = 32768;
            tab[k] = 16'(e);
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine();

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mul;
        logic       pos;
        logic       rd_issue;
        logic [1:0] rd_sel;
        logic       c1;
        logic       c2;
        logic       c3;
        logic       commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

@@ rtl/vmd_in_if.sv @@
interface vmd_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

@@ rtl/vmd_out_if.sv @@
interface vmd_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [23:0]   sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

@@ rtl/vmd_ctrl.sv @@
module vmd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  vmd_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output vmd_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_POS  = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_RDW  = 4'd4;
    localparam logic [3:0] S_C1   = 4'd5;
    localparam logic [3:0] S_C2   = 4'd6;
    localparam logic [3:0] S_C3   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [1:0] r_k, n_k;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // sequencing and commands
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_POS;
            end
            S_POS: begin
                o_cmd.pos = 1'b1;
                n_k       = 2'd0;
                n_state   = S_RD;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_sel   = r_k;
                n_k            = r_k + 2'd1;
                if (r_k == 2'd3) n_state = S_RDW;
            end
            S_RDW: n_state = S_C1;
            S_C1: begin
                o_cmd.c1 = 1'b1;
                n_state  = S_C2;
            end
            S_C2: begin
                o_cmd.c2 = 1'b1;
                n_state  = S_C3;
            end
            S_C3: begin
                o_cmd.c3 = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ rtl/vmd_datapath.sv @@
module vmd_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vmd_pkg::t_cmd        i_cmd,
    output vmd_pkg::t_sts        o_sts,
    input  logic signed [23:0]   i_sample_in,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [23:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [23:0]   o_sample_out
);

    localparam int AW    = vmd_pkg::AW;
    localparam int SAW   = vmd_pkg::SAW;
    localparam int ACC_W = vmd_pkg::ACC_W;

    // configuration registers
    logic [19:0] r_delay_width;
    logic [23:0] r_phase_step;
    logic [1:0]  r_waveform;
    logic [1:0]  r_interp_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_width <= vmd_pkg::RST_DELAY_WIDTH;
            r_phase_step  <= vmd_pkg::RST_PHASE_STEP;
            r_waveform    <= vmd_pkg::RST_WAVEFORM;
            r_interp_mode <= vmd_pkg::RST_INTERP_MODE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vmd_pkg::CFG_DELAY_WIDTH: r_delay_width <= i_cfg_data[19:0];
                vmd_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data;
                vmd_pkg::CFG_WAVEFORM:    r_waveform    <= i_cfg_data[1:0];
                vmd_pkg::CFG_INTERP_MODE: r_interp_mode <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // lfo shape from current phase
    logic [31:0]    r_phase;
    logic [15:0]    ph;
    logic [1:0]     quad;
    logic [SAW-1:0] tab_i;
    logic [SAW:0]   tab_idx;
    logic [15:0]    tab_s;
    logic [17:0]    lfo;

    assign ph      = r_phase[31:16];
    assign quad    = r_phase[31:30];
    assign tab_i   = r_phase[29 -: SAW];
    assign tab_idx = quad[0] ? (SAW+1)'(vmd_pkg::SINE_TABLE_DEPTH) - {1'b0, tab_i}
                             : {1'b0, tab_i};
    assign tab_s   = vmd_pkg::SINE_TAB[tab_idx];

    always_comb begin
        case (r_waveform)
            vmd_pkg::WAVE_SINE:
                lfo = quad[1] ? 18'd32768 - {2'b0, tab_s} : 18'd32768 + {2'b0, tab_s};
            vmd_pkg::WAVE_TRI: begin
                if (ph < 16'd16384)      lfo = 18'd32768 + {1'b0, ph, 1'b0};
                else if (ph < 16'd49152) lfo = 18'd98304 - {1'b0, ph, 1'b0};
                else                     lfo = {1'b0, ph, 1'b0} - 18'd98304;
            end
            vmd_pkg::WAVE_SAW:
                lfo = ph[15] ? {2'b0, ph} - 18'd32768 : {2'b0, ph} + 18'd32768;
            default:
                lfo = ph[15] ? 18'd98304 - {2'b0, ph} : 18'd32768 - {2'b0, ph};
        endcase
    end

    // item capture, delay product and read position
    logic signed [23:0]      r_x;
    logic [16:0]             r_lfo;
    logic [36:0]             r_d;
    logic [AW-1:0]           r_base;
    logic [15:0]             r_frac;
    logic [AW-1:0]           r_wp;
    logic [vmd_pkg::POS_W-1:0] pos;

    assign pos = {r_wp - AW'(1), 24'b0} - vmd_pkg::POS_W'(r_d);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_sample_in;
            r_lfo <= lfo[16:0];
        end
        if (i_cmd.mul) r_d <= r_delay_width * r_lfo;
        if (i_cmd.pos) begin
            r_base <= pos[vmd_pkg::POS_W-1:24];
            r_frac <= pos[23:8];
        end
    end

    // delay store, unwritten entries masked by the fill count
    logic signed [23:0] mem [0:vmd_pkg::DELAY_DEPTH-1];
    logic [AW:0]        r_fill;
    logic [AW-1:0]      rd_addr;
    logic signed [23:0] r_rdata;
    logic               r_cap;
    logic [1:0]         r_cap_sel;
    logic               r_cap_ok;

    assign rd_addr = r_base + AW'(i_cmd.rd_sel) - AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) mem[r_wp] <= r_x;
        r_rdata   <= mem[rd_addr];
        r_cap_sel <= i_cmd.rd_sel;
        r_cap_ok  <= {1'b0, rd_addr} < r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= 1'b0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_phase <= '0;
        end else begin
            r_cap <= i_cmd.rd_issue;
            if (i_cmd.commit) begin
                r_wp    <= r_wp + AW'(1);
                r_phase <= r_phase + {8'b0, r_phase_step};
                if (r_fill != (AW+1)'(vmd_pkg::DELAY_DEPTH)) r_fill <= r_fill + (AW+1)'(1);
            end
        end
    end

    // neighbour samples
    logic signed [23:0] r_sm, r_s0, r_s1, r_s2;
    logic signed [23:0] cap_val;

    assign cap_val = r_cap_ok ? r_rdata : 24'sd0;

    always_ff @(posedge i_clk) begin
        if (r_cap) begin
            case (r_cap_sel)
                2'd0:    r_sm <= cap_val;
                2'd1:    r_s0 <= cap_val;
                2'd2:    r_s1 <= cap_val;
                default: r_s2 <= cap_val;
            endcase
        end
    end

    // interpolation arithmetic, one cubic multiply shared by the three steps
    logic signed [ACC_W-1:0] b0, b1, b2;
    logic signed [ACC_W-1:0] mul_a;
    logic signed [16:0]      frac_s;
    logic signed [ACC_W+16:0] prod;
    logic signed [24:0]      diff;
    logic signed [41:0]      lin_prod;
    logic signed [ACC_W-1:0] r_acc, r_lin, r_ycub;

    assign b0 = ACC_W'(-ACC_W'(r_sm) + 3 * ACC_W'(r_s0) - 3 * ACC_W'(r_s1)
                       + ACC_W'(r_s2));
    assign b1 = ACC_W'(2 * ACC_W'(r_sm) - 5 * ACC_W'(r_s0) + 4 * ACC_W'(r_s1)
                       - ACC_W'(r_s2));
    assign b2 = ACC_W'(r_s1) - ACC_W'(r_sm);

    assign frac_s   = $signed({1'b0, r_frac});
    assign mul_a    = i_cmd.c1 ? b0 : r_acc;
    assign prod     = mul_a * frac_s;
    assign diff     = 25'(r_s1) - 25'(r_s0);
    assign lin_prod = diff * frac_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.c1) begin
            r_acc <= ACC_W'(prod >>> 16) + b1;
            r_lin <= ACC_W'(r_s0) + ACC_W'(lin_prod >>> 16);
        end
        if (i_cmd.c2) r_acc  <= ACC_W'(prod >>> 16) + b2;
        if (i_cmd.c3) r_ycub <= ACC_W'(r_s0) + ACC_W'(prod >>> 17);
    end

    // mode select and saturation
    logic signed [ACC_W-1:0] y_sel;
    logic signed [23:0]      y_sat;

    always_comb begin
        case (r_interp_mode)
            vmd_pkg::INTERP_NEAREST: y_sel = ACC_W'(r_s0);
            vmd_pkg::INTERP_LINEAR:  y_sel = r_lin;
            vmd_pkg::INTERP_CUBIC:   y_sel = r_ycub;
            default:                 y_sel = '0;
        endcase
        if (y_sel > ACC_W'(24'sh7FFFFF))       y_sat = 24'sh7FFFFF;
        else if (y_sel < -ACC_W'(25'sh800000)) y_sat = -24'sh800000;
        else                                   y_sat = y_sel[23:0];
    end

    // output register
    logic               r_ov;
    logic signed [23:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_cmd.commit) r_ov <= 1'b1;
        else if (i_out_ready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_out <= y_sat;
    end

    assign o_sts.out_free = !r_ov || i_out_ready;
    assign o_out_valid    = r_ov;
    assign o_sample_out   = r_out;

endmodule

@@ rtl/vibrato_modulated_delay_top.sv @@
// Mono vibrato on a 4096-sample circular delay line. Each accepted input sample gives one
// output sample, read behind the write pointer by delay_width times an LFO (sine, triangle,
// sawtooth or inverse sawtooth), with nearest, linear or cubic interpolation. Each item goes
// through the delay product, the read position, four reads through the single delay-memory
// port and three dependent multiply steps of the cubic form, then waits until the output
// register is free before its result enters it. Input is taken again only after that, so
// one item is in flight at a time. Entries not yet written after reset read as zero through
// a fill count; there is no clearing pass. Configuration writes take effect at once and are
// meant for when the block is idle.
module vibrato_modulated_delay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vmd_in_if.sink      i_in_ch,
    vmd_out_if.source   o_out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data
);

    vmd_pkg::t_cmd cmd;
    vmd_pkg::t_sts sts;
    logic          in_ready;

    assign i_in_ch.ready = in_ready;

    // sequencer
    vmd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // datapath
    vmd_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample_in  (i_in_ch.sample_in),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_ch.valid),
        .i_out_ready  (o_out_ch.ready),
        .o_sample_out (o_out_ch.sample_out)
    );

    // one item in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a commit always presents a result
    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_out_ch.valid)
        else $error("commit without output valid");

    // load only on an offered item
    a_load_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (i_in_ch.valid && in_ready))
        else $error("load without accepted item");

    // at most one datapath step per cycle
    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul, cmd.pos, cmd.rd_issue, cmd.c1, cmd.c2, cmd.c3,
                  cmd.commit}))
        else $error("overlapping datapath commands");

endmodule

@@ test/vmd_tb_if.sv @@
`timescale 1ns / 1ps

// the channel interfaces come from the rtl; this file holds the test-side idle helper
interface vmd_idle_if (input logic i_clk);
    bit quiet;
endinterface

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    vmd_in_if  in_ch ();
    vmd_out_if out_ch ();
    vmd_idle_if idle (.i_clk(i_clk));

    vibrato_modulated_delay_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_ch   (in_ch),
        .o_out_ch  (out_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // vibrato predictor and queue of expected samples
    class vibrato_board;
        logic signed [23:0] store [0:vmd_pkg::DELAY_DEPTH-1];
        logic [11:0]        wptr;
        logic [31:0]        phase;
        logic [19:0]        width;
        logic [23:0]        step;
        logic [1:0]         wave;
        logic [1:0]         interp;
        int                 sine [0:vmd_pkg::SINE_TABLE_DEPTH];
        logic signed [23:0] due_samples [$];
        int                 errors;

        function new();
            longint unsigned dv [0:6];
            longint unsigned x, x2, term;
            longint          sum, e;
            dv = '{6, 20, 42, 72, 110, 156, 210};
            for (int k = 0; k <= vmd_pkg::SINE_TABLE_DEPTH; k++) begin
                x    = (longint'(k) * 64'd1686629713) / vmd_pkg::SINE_TABLE_DEPTH;
                x2   = (x * x) >> 30;
                term = x;
                sum  = longint'(x);
                for (int n = 0; n < 7; n++) begin
                    term = ((term * x2) >> 30) / dv[n];
                    if (n % 2 == 1) sum = sum + longint'(term);
                    else            sum = sum - longint'(term);
                end
                if (sum < 0) sum = 0;
                e = (sum * 32768 + (64'sd1 <<< 29)) >>> 30;
                if (e > 32768) e = 32768;
                sine[k] = int'(e);
            end
            for (int k = 0; k < vmd_pkg::DELAY_DEPTH; k++) store[k] = '0;
            wptr   = '0;
            phase  = '0;
            width  = vmd_pkg::RST_DELAY_WIDTH;
            step   = vmd_pkg::RST_PHASE_STEP;
            wave   = vmd_pkg::RST_WAVEFORM;
            interp = vmd_pkg::RST_INTERP_MODE;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] v);
            case (idx)
                vmd_pkg::CFG_DELAY_WIDTH: width  = v[19:0];
                vmd_pkg::CFG_PHASE_STEP:  step   = v;
                vmd_pkg::CFG_WAVEFORM:    wave   = v[1:0];
                default:                  interp = v[1:0];
            endcase
        endfunction

        function longint lfo_level();
            longint ph, i, s;
            ph = longint'(phase[31:16]);
            case (wave)
                vmd_pkg::WAVE_SINE: begin
                    i = longint'(phase[29:0]) * vmd_pkg::SINE_TABLE_DEPTH >>> 30;
                    s = phase[30] ? sine[vmd_pkg::SINE_TABLE_DEPTH - i] : sine[i];
                    if (phase[31]) s = -s;
                    return 32768 + s;
                end
                vmd_pkg::WAVE_TRI: begin
                    if (ph < 16384) return 32768 + 2 * ph;
                    if (ph < 49152) return 65536 - 2 * (ph - 16384);
                    return 2 * (ph - 49152);
                end
                vmd_pkg::WAVE_SAW: return ph < 32768 ? 32768 + ph : ph - 32768;
                default:           return ph < 32768 ? 32768 - ph : 98304 - ph;
            endcase
        endfunction

        // shifts of signed longints floor toward minus infinity
        function void note_input(logic signed [23:0] x);
            logic [35:0] pos;
            logic [11:0] base;
            longint      fr, sm, s0, s1, s2, b0, b1, b2, acc, y;
            pos  = {wptr - 12'd1, 24'd0} - 36'(longint'(width) * lfo_level());
            base = pos[35:24];
            fr   = longint'(pos[23:8]);
            sm   = store[base - 12'd1];
            s0   = store[base];
            s1   = store[base + 12'd1];
            s2   = store[base + 12'd2];
            case (interp)
                vmd_pkg::INTERP_NEAREST: y = s0;
                vmd_pkg::INTERP_LINEAR:  y = s0 + ((fr * (s1 - s0)) >>> 16);
                vmd_pkg::INTERP_CUBIC: begin
                    b0  = -sm + 3 * s0 - 3 * s1 + s2;
                    b1  = 2 * sm - 5 * s0 + 4 * s1 - s2;
                    b2  = s1 - sm;
                    acc = ((b0 * fr) >>> 16) + b1;
                    acc = ((acc * fr) >>> 16) + b2;
                    y   = s0 + ((acc * fr) >>> 17);
                end
                default: y = 0;
            endcase
            if (y > 8388607) y = 8388607;
            if (y < -8388608) y = -8388608;
            due_samples.push_back(24'(y));
            store[wptr] = x;
            wptr  = wptr + 12'd1;
            phase = phase + 32'(step);
        endfunction

        function void check_output(logic signed [23:0] got);
            logic signed [23:0] want;
            if (due_samples.size() == 0) begin
                $display("%0t: unexpected sample_out, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = due_samples.pop_front();
            if (got !== want) begin
                $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                         $time, want, got);
                errors++;
            end
        endfunction
    endclass

    vibrato_board board;

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // monitor both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note_input(in_ch.sample_in);
            if (out_ch.valid && out_ch.ready) board.check_output(out_ch.sample_out);
        end
    end

    // output stall in bursts
    initial begin
        int n;
        out_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (!idle.quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                out_ch.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    // valid stays high into the next item unless an idle burst or a drain follows
    task automatic send_sample(logic signed [23:0] x);
        if (!idle.quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.due_samples.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 24'sh7FFFFF;
            1:       return -24'sh800000;
            2:       return 24'($urandom_range(0, 2000)) - 24'sd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        logic signed [23:0] edge_vals [0:5];
        edge_vals = '{24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sd1, 24'sd1, 24'sh555555};
        board          = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = vmd_pkg::CFG_DELAY_WIDTH;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.sample_in = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes under reset settings, then each mode and shape
        for (int k = 0; k < 6; k++) send_sample(edge_vals[k]);
        drain();
        write_reg(vmd_pkg::CFG_DELAY_WIDTH, 24'd1048320);
        write_reg(vmd_pkg::CFG_PHASE_STEP, 24'hFFFFFF);
        for (int m = 0; m < 4; m++) begin
            drain();
            write_reg(vmd_pkg::CFG_INTERP_MODE, 24'(m));
            write_reg(vmd_pkg::CFG_WAVEFORM, 24'(m));
            for (int k = 0; k < 4; k++) send_sample(edge_vals[(k + m) % 6]);
        end
        drain();

        // random phases with fresh settings
        for (int p = 0; p < 33; p++) begin
            case ($urandom_range(0, 3))
                0:       write_reg(vmd_pkg::CFG_DELAY_WIDTH, 24'd0);
                1:       write_reg(vmd_pkg::CFG_DELAY_WIDTH, 24'd1048320);
                default: write_reg(vmd_pkg::CFG_DELAY_WIDTH,
                                   24'($urandom_range(0, 1048320)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(vmd_pkg::CFG_PHASE_STEP, 24'd0);
                1:       write_reg(vmd_pkg::CFG_PHASE_STEP, 24'hFFFFFF);
                default: write_reg(vmd_pkg::CFG_PHASE_STEP, 24'($urandom));
            endcase
            write_reg(vmd_pkg::CFG_WAVEFORM, 24'($urandom_range(0, 3)));
            write_reg(vmd_pkg::CFG_INTERP_MODE,
                      $urandom_range(0, 9) == 0 ? 24'd3 : 24'($urandom_range(0, 2)));
            if (p >= 28) idle.quiet = 1'b1;
            for (int k = 0; k < 50; k++) send_sample(pick_sample());
            drain();
        end

        if (board.errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end

    // timeout
    initial begin
        #20_000_000;
        $display("testbench failed");
        $finish;
    end
endmodule
